FILE: src/rpls_pkg.sv
// Package for the remote pulse length serializer.
// Holds item, result and configuration types and the fixed timing constants.
// No dependencies.
package rpls_pkg;

  localparam int unsigned CODE_W     = 7;
  localparam int unsigned ADDR_W     = 7;
  localparam int unsigned REPEAT_W   = 3;
  localparam int unsigned CFG_DATA_W = 7;
  localparam int unsigned CFG_IDX_W  = 1;
  localparam int unsigned TICK_W     = 5;
  localparam int unsigned BITPOS_W   = 5;
  localparam int unsigned FRAME_W    = ADDR_W + CODE_W;

  localparam int unsigned QUEUE_DEPTH = 2;
  localparam int unsigned QPTR_W      = 1;
  localparam int unsigned QCNT_W      = 2;

  localparam logic [TICK_W-1:0]   HDR_LOW_TICKS  = 5'd16;
  localparam logic [TICK_W-1:0]   HDR_HIGH_TICKS = 5'd8;
  localparam logic [TICK_W-1:0]   ONE_HIGH_TICKS = 5'd3;
  localparam logic [TICK_W-1:0]   ONE_TICK       = 5'd1;
  localparam logic [BITPOS_W-1:0] LAST_BIT       = 5'd16;

  localparam logic [REPEAT_W-1:0] REPEAT_RST = 3'd3;
  localparam logic [ADDR_W-1:0]   ADDR_RST   = 7'h47;

  // item kinds
  localparam logic CMD_TICK = 1'b0;
  localparam logic CMD_SEND = 1'b1;

  // configuration register indexes
  localparam logic [CFG_IDX_W-1:0] CFG_REPEAT = 1'b0;
  localparam logic [CFG_IDX_W-1:0] CFG_ADDR   = 1'b1;

  typedef struct packed {
    logic [REPEAT_W-1:0] repeat_count;
    logic [ADDR_W-1:0]   device_address;
  } cfg_t;

  typedef struct packed {
    logic              is_send;
    logic [CODE_W-1:0] code;
  } q_entry_t;

  // head of the queue as seen by the back end
  typedef struct packed {
    logic     valid;
    q_entry_t entry;
  } q_head_t;

  typedef struct packed {
    logic line_level;
    logic sending;
    logic sequence_done;
    logic request_refused;
  } result_t;

endpackage

FILE: src/rpls_in_if.sv
// Input channel of the remote pulse length serializer.
// Valid/ready handshake carrying cmd and button_code. Depends on rpls_pkg.
interface rpls_in_if;
  logic                       valid;
  logic                       ready;
  logic                       cmd;
  logic [rpls_pkg::CODE_W-1:0] button_code;

  modport source (output valid, output cmd, output button_code, input ready);
  modport sink   (input valid, input cmd, input button_code, output ready);
endinterface

FILE: src/rpls_out_if.sv
// Result channel of the remote pulse length serializer.
// Valid/ready handshake carrying the four one-bit result fields.
interface rpls_out_if;
  logic valid;
  logic ready;
  logic line_level;
  logic sending;
  logic sequence_done;
  logic request_refused;

  modport source (output valid, output line_level, output sending,
                  output sequence_done, output request_refused, input ready);
  modport sink   (input valid, input line_level, input sending,
                  input sequence_done, input request_refused, output ready);
endinterface

FILE: src/remote_pulse_length_serializer.sv
// Top level of the remote pulse length serializer: configuration registers,
// front end queue and back end sequencer. Depends on rpls_pkg, the channel
// interfaces, rpls_front and rpls_back.
//
// Usage: in_if carries items; cmd 0 is one timing tick, cmd 1 asks to send
// button_code. Every item gives exactly one item on out_if: the line level
// for that tick, whether a transmission is running, the end-of-sequence flag
// and the refused flag for a send that arrives while busy.
// The config port writes repeat_count (index 0) and device_address (index 1)
// on any cycle with cfg_we_i high; write only while the block is idle.
// An accepted item is written into the queue; the sequencer then steps on it and
// its result is registered in the output register, from which out_if takes it.
// Throughput: one item per cycle while out_if is ready; the sequencer step and output
// register are the only stage in the loop.
// When out_if stalls the result register holds; the queue absorbs two more
// items, after which in_if.ready drops.
// Reset: asynchronous, active low; the line rests released, the queue is
// emptied and the registers return to three repeats and address 0x47.
module remote_pulse_length_serializer (
  input  logic                             clk_i,
  input  logic                             rst_ni,
  rpls_in_if.sink                          in_if,
  rpls_out_if.source                       out_if,
  input  logic                             cfg_we_i,
  input  logic [rpls_pkg::CFG_IDX_W-1:0]   cfg_idx_i,
  input  logic [rpls_pkg::CFG_DATA_W-1:0]  cfg_wdata_i
);

  rpls_pkg::cfg_t    cfg_q;
  rpls_pkg::q_head_t head;
  logic              pop;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cfg_q.repeat_count   <= rpls_pkg::REPEAT_RST;
      cfg_q.device_address <= rpls_pkg::ADDR_RST;
    end else if (cfg_we_i) begin
      case (cfg_idx_i)
        rpls_pkg::CFG_REPEAT: cfg_q.repeat_count   <= cfg_wdata_i[rpls_pkg::REPEAT_W-1:0];
        rpls_pkg::CFG_ADDR:   cfg_q.device_address <= cfg_wdata_i[rpls_pkg::ADDR_W-1:0];
        default: ;
      endcase
    end
  end

  rpls_front u_front (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .in_if  (in_if),
    .pop_i  (pop),
    .head_o (head)
  );

  rpls_back u_back (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .cfg_i  (cfg_q),
    .head_i (head),
    .pop_o  (pop),
    .out_if (out_if)
  );

  // the back end only steps on a queued item
  a_pop_needs_item: assert property (@(posedge clk_i) disable iff (!rst_ni)
    pop |-> head.valid)
    else $error("sequencer stepped with an empty queue");

  // the final tick still belongs to the transmission and is released
  a_done_ends_send: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_if.valid && out_if.sequence_done |-> out_if.sending && out_if.line_level)
    else $error("sequence end reported outside a transmission");

  a_refused_busy: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_if.valid && out_if.request_refused |-> out_if.sending)
    else $error("request refused while idle");

  a_low_only_busy: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_if.valid && !out_if.line_level |-> out_if.sending)
    else $error("line driven low while idle");

endmodule

FILE: src/rpls_front.sv
// Front end: accepts input items, classifies them and holds them in a
// two-entry queue for the back end. Depends on rpls_pkg and rpls_in_if.
module rpls_front (
  input  logic              clk_i,
  input  logic              rst_ni,
  rpls_in_if.sink           in_if,
  input  logic              pop_i,
  output rpls_pkg::q_head_t head_o
);

  rpls_pkg::q_entry_t                entry_q [rpls_pkg::QUEUE_DEPTH];
  logic [rpls_pkg::QPTR_W-1:0]      wr_ptr_q, rd_ptr_q;
  logic [rpls_pkg::QCNT_W-1:0]      cnt_q;
  logic                             push;
  logic                             pop;
  rpls_pkg::q_entry_t               new_entry;

  assign in_if.ready = (cnt_q != rpls_pkg::QCNT_W'(rpls_pkg::QUEUE_DEPTH));
  assign push        = in_if.valid && in_if.ready;
  assign pop         = pop_i && (cnt_q != '0);

  always_comb begin
    new_entry.is_send = (in_if.cmd == rpls_pkg::CMD_SEND);
    new_entry.code    = in_if.button_code;
  end

  assign head_o.valid = (cnt_q != '0);
  assign head_o.entry = entry_q[rd_ptr_q];

  always_ff @(posedge clk_i) begin
    if (push) begin
      entry_q[wr_ptr_q] <= new_entry;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= '0;
      rd_ptr_q <= '0;
      cnt_q    <= '0;
    end else begin
      if (push) wr_ptr_q <= wr_ptr_q + 1'b1;
      if (pop)  rd_ptr_q <= rd_ptr_q + 1'b1;
      if (push && !pop) cnt_q <= cnt_q + 1'b1;
      else if (pop && !push) cnt_q <= cnt_q - 1'b1;
    end
  end

endmodule

FILE: src/rpls_back.sv
// Back end: frame sequencer that steps once per queued item and writes one
// result into the output register. Depends on rpls_pkg and rpls_out_if.
module rpls_back (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  rpls_pkg::cfg_t    cfg_i,
  input  rpls_pkg::q_head_t head_i,
  output logic              pop_o,
  rpls_out_if.source        out_if
);

  typedef enum logic [2:0] {
    PH_IDLE     = 3'd0,
    PH_RESET    = 3'd1,
    PH_HDR_LOW  = 3'd2,
    PH_HDR_HIGH = 3'd3,
    PH_BIT_LOW  = 3'd4,
    PH_BIT_HIGH = 3'd5
  } phase_e;

  logic                              busy_q, busy_d;
  logic [rpls_pkg::REPEAT_W-1:0]     rep_q, rep_d;
  phase_e                            phase_q, phase_d;
  logic [rpls_pkg::BITPOS_W-1:0]     bitpos_q, bitpos_d;
  logic [rpls_pkg::TICK_W-1:0]       ticks_q, ticks_d;
  logic [rpls_pkg::FRAME_W-1:0]      frame_q, frame_d;
  logic                              out_valid_q;
  rpls_pkg::result_t                 res_q, res_d;

  logic                              fire;
  logic                              cur_level;
  logic                              cur_bit;
  logic                              phase_ok;
  logic [rpls_pkg::BITPOS_W-1:0]     bit_m1;
  logic [rpls_pkg::FRAME_W+1:0]      frame_ext;

  assign fire  = head_i.valid && (!out_valid_q || out_if.ready);
  assign pop_o = fire;

  assign cur_level = !(busy_q && (phase_q == PH_HDR_LOW || phase_q == PH_BIT_LOW));
  assign phase_ok  = (phase_q != PH_IDLE) && (phase_q <= PH_BIT_HIGH);

  // start bit (wraps to the top bit) and stop bits read the padding ones
  assign bit_m1    = bitpos_q - 1'b1;
  assign frame_ext = {2'b11, frame_q};
  assign cur_bit   = frame_ext[bit_m1[3:0]];

  always_comb begin
    busy_d   = busy_q;
    rep_d    = rep_q;
    phase_d  = phase_q;
    bitpos_d = bitpos_q;
    ticks_d  = ticks_q;
    frame_d  = frame_q;
    res_d    = '{line_level: 1'b1, sending: 1'b0, sequence_done: 1'b0,
                 request_refused: 1'b0};

    if (head_i.entry.is_send) begin
      res_d.sending = 1'b1;
      if (busy_q) begin
        res_d.request_refused = 1'b1;
        res_d.line_level      = cur_level;
      end else begin
        busy_d   = 1'b1;
        rep_d    = (cfg_i.repeat_count == '0) ? 3'd1 : cfg_i.repeat_count;
        phase_d  = PH_RESET;
        bitpos_d = '0;
        ticks_d  = rpls_pkg::ONE_TICK;
        frame_d  = {head_i.entry.code, cfg_i.device_address};
      end
    end else if (busy_q) begin
      if (!phase_ok) begin
        busy_d   = 1'b0;
        rep_d    = '0;
        phase_d  = PH_IDLE;
        bitpos_d = '0;
        ticks_d  = '0;
      end else begin
        res_d.line_level = cur_level;
        res_d.sending    = 1'b1;
        if (ticks_q > rpls_pkg::ONE_TICK) begin
          ticks_d = ticks_q - 1'b1;
        end else begin
          case (phase_q)
            PH_RESET: begin
              phase_d = PH_HDR_LOW;
              ticks_d = rpls_pkg::HDR_LOW_TICKS;
            end
            PH_HDR_LOW: begin
              phase_d = PH_HDR_HIGH;
              ticks_d = rpls_pkg::HDR_HIGH_TICKS;
            end
            PH_HDR_HIGH: begin
              phase_d  = PH_BIT_LOW;
              bitpos_d = '0;
              ticks_d  = rpls_pkg::ONE_TICK;
            end
            PH_BIT_LOW: begin
              phase_d = PH_BIT_HIGH;
              ticks_d = cur_bit ? rpls_pkg::ONE_HIGH_TICKS : rpls_pkg::ONE_TICK;
            end
            PH_BIT_HIGH: begin
              if (bitpos_q < rpls_pkg::LAST_BIT) begin
                bitpos_d = bitpos_q + 1'b1;
                phase_d  = PH_BIT_LOW;
                ticks_d  = rpls_pkg::ONE_TICK;
              end else if (rep_q > 3'd1) begin
                rep_d    = rep_q - 1'b1;
                phase_d  = PH_RESET;
                bitpos_d = '0;
                ticks_d  = rpls_pkg::ONE_TICK;
              end else begin
                busy_d              = 1'b0;
                rep_d               = '0;
                phase_d             = PH_IDLE;
                bitpos_d            = '0;
                ticks_d             = '0;
                res_d.sequence_done = 1'b1;
              end
            end
            default: begin
              busy_d   = 1'b0;
              rep_d    = '0;
              phase_d  = PH_IDLE;
              bitpos_d = '0;
              ticks_d  = '0;
            end
          endcase
        end
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q      <= 1'b0;
      rep_q       <= '0;
      phase_q     <= PH_IDLE;
      bitpos_q    <= '0;
      ticks_q     <= '0;
      frame_q     <= '0;
      out_valid_q <= 1'b0;
      res_q       <= '0;
    end else begin
      if (fire) begin
        busy_q      <= busy_d;
        rep_q       <= rep_d;
        phase_q     <= phase_d;
        bitpos_q    <= bitpos_d;
        ticks_q     <= ticks_d;
        frame_q     <= frame_d;
        res_q       <= res_d;
        out_valid_q <= 1'b1;
      end else if (out_if.ready) begin
        out_valid_q <= 1'b0;
      end
    end
  end

  assign out_if.valid           = out_valid_q;
  assign out_if.line_level      = res_q.line_level;
  assign out_if.sending         = res_q.sending;
  assign out_if.sequence_done   = res_q.sequence_done;
  assign out_if.request_refused = res_q.request_refused;

endmodule

FILE: dv/rpls_checker.sv
`timescale 1ns / 100ps
// Result checker for remote_pulse_length_serializer: watches the item channels
// and the register port, predicts every result item and compares it per field.
// Depends on rpls_pkg, rpls_in_if and rpls_out_if.
module rpls_checker
  import rpls_pkg::*;
(
  input  logic                  clk_i,
  input  logic                  rst_ni,
  rpls_in_if                    in_mon,
  rpls_out_if                   out_mon,
  input  logic                  cfg_we_i,
  input  logic [CFG_IDX_W-1:0]  cfg_idx_i,
  input  logic [CFG_DATA_W-1:0] cfg_wdata_i,
  output int unsigned           err_cnt_o,
  output int unsigned           pend_cnt_o
);

  typedef enum logic [2:0] {
    SEG_IDLE, SEG_BUS_RESET, SEG_HDR_LOW, SEG_HDR_REL, SEG_BIT_LOW, SEG_BIT_REL
  } seg_e;

  logic                busy;
  logic [REPEAT_W-1:0] reps_left;
  seg_e                seg;
  logic [BITPOS_W-1:0] bit_pos;
  logic [TICK_W-1:0]   ticks;
  logic [FRAME_W-1:0]  frame;
  logic [REPEAT_W-1:0] cfg_repeat;
  logic [ADDR_W-1:0]   cfg_addr;

  result_t line_res_q[$];

  string field_name [$bits(result_t)] =
    '{"request_refused", "sequence_done", "sending", "line_level"};

  function automatic void go_idle();
    busy      = 1'b0;
    reps_left = '0;
    seg       = SEG_IDLE;
    bit_pos   = '0;
    ticks     = '0;
  endfunction

  function automatic logic seg_level();
    return (busy && (seg == SEG_HDR_LOW || seg == SEG_BIT_LOW)) ? 1'b0 : 1'b1;
  endfunction

  function automatic logic frame_bit();
    if (bit_pos == '0 || bit_pos > BITPOS_W'(14)) return 1'b1;
    return frame[bit_pos - 1'b1];
  endfunction

  // one item through the line sequencer
  function automatic result_t step_line(input logic cmd, input logic [CODE_W-1:0] code);
    result_t r;
    r = '0;
    r.line_level = 1'b1;
    if (cmd == CMD_SEND) begin
      if (busy) begin
        r.request_refused = 1'b1;
      end else begin
        busy      = 1'b1;
        reps_left = (cfg_repeat == '0) ? REPEAT_W'(1) : cfg_repeat;
        seg       = SEG_BUS_RESET;
        bit_pos   = '0;
        ticks     = ONE_TICK;
        frame     = {code, cfg_addr};
      end
      r.line_level = seg_level();
      r.sending    = busy;
    end else if (busy) begin
      r.line_level = seg_level();
      r.sending    = 1'b1;
      if (ticks > ONE_TICK) begin
        ticks = ticks - 1'b1;
      end else begin
        case (seg)
          SEG_BUS_RESET: begin
            seg   = SEG_HDR_LOW;
            ticks = HDR_LOW_TICKS;
          end
          SEG_HDR_LOW: begin
            seg   = SEG_HDR_REL;
            ticks = HDR_HIGH_TICKS;
          end
          SEG_HDR_REL: begin
            seg     = SEG_BIT_LOW;
            bit_pos = '0;
            ticks   = ONE_TICK;
          end
          SEG_BIT_LOW: begin
            seg   = SEG_BIT_REL;
            ticks = frame_bit() ? ONE_HIGH_TICKS : ONE_TICK;
          end
          SEG_BIT_REL: begin
            if (bit_pos < LAST_BIT) begin
              bit_pos = bit_pos + 1'b1;
              seg     = SEG_BIT_LOW;
              ticks   = ONE_TICK;
            end else if (reps_left > REPEAT_W'(1)) begin
              reps_left = reps_left - 1'b1;
              seg       = SEG_BUS_RESET;
              bit_pos   = '0;
              ticks     = ONE_TICK;
            end else begin
              go_idle();
              r.sequence_done = 1'b1;
            end
          end
          default: begin
            go_idle();
            r.line_level = 1'b1;
            r.sending    = 1'b0;
          end
        endcase
      end
    end
    return r;
  endfunction

  always @(posedge clk_i or negedge rst_ni) begin
    result_t got;
    result_t want;
    if (!rst_ni) begin
      go_idle();
      frame      = '0;
      cfg_repeat = REPEAT_RST;
      cfg_addr   = ADDR_RST;
      line_res_q.delete();
      pend_cnt_o = 0;
    end else begin
      if (out_mon.valid && out_mon.ready) begin
        got = {out_mon.line_level, out_mon.sending, out_mon.sequence_done,
               out_mon.request_refused};
        if (line_res_q.size() == 0) begin
          err_cnt_o++;
          $display("%0t: result item %b with none expected", $time, got);
        end else begin
          want = line_res_q.pop_front();
          for (int i = 0; i < $bits(result_t); i++) begin
            if (got[i] !== want[i]) begin
              err_cnt_o++;
              $display("%0t: %s expected %b got %b", $time, field_name[i], want[i], got[i]);
            end
          end
        end
      end
      if (cfg_we_i) begin
        case (cfg_idx_i)
          CFG_REPEAT: cfg_repeat = cfg_wdata_i[REPEAT_W-1:0];
          CFG_ADDR:   cfg_addr   = cfg_wdata_i[ADDR_W-1:0];
          default:    ;
        endcase
      end
      if (in_mon.valid && in_mon.ready) begin
        line_res_q.push_back(step_line(in_mon.cmd, in_mon.button_code));
      end
      pend_cnt_o = line_res_q.size();
    end
  end

endmodule

FILE: dv/remote_pulse_length_serializer_tb.sv
`timescale 1ns / 100ps
// Testbench top for remote_pulse_length_serializer: clock, reset, bursty item
// stimulus, result back-pressure and the verdict.
// Depends on rpls_pkg, rpls_in_if, rpls_out_if and rpls_checker.
module remote_pulse_length_serializer_tb;
  import rpls_pkg::*;

  localparam int unsigned CYCLE_LIMIT = 200000;

  typedef enum logic [1:0] {RX_FREE, RX_COIN, RX_BURSTY} rx_mode_e;

  logic                  clk_i       = 1'b0;
  logic                  rst_ni      = 1'b0;
  logic                  cfg_we_i    = 1'b0;
  logic [CFG_IDX_W-1:0]  cfg_idx_i   = CFG_REPEAT;
  logic [CFG_DATA_W-1:0] cfg_wdata_i = '0;

  int unsigned err_cnt;
  int unsigned pend_cnt;
  int unsigned cycle_cnt    = 0;
  int unsigned burst_left   = 1;
  int unsigned rx_mode_left = 0;
  int unsigned rx_hold_left = 0;
  rx_mode_e    rx_mode      = RX_FREE;
  logic        rx_lvl       = 1'b1;

  rpls_in_if  in_ch ();
  rpls_out_if out_ch ();

  remote_pulse_length_serializer i_dut (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_if       (in_ch),
    .out_if      (out_ch),
    .cfg_we_i    (cfg_we_i),
    .cfg_idx_i   (cfg_idx_i),
    .cfg_wdata_i (cfg_wdata_i)
  );

  rpls_checker i_checker (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_mon      (in_ch),
    .out_mon     (out_ch),
    .cfg_we_i    (cfg_we_i),
    .cfg_idx_i   (cfg_idx_i),
    .cfg_wdata_i (cfg_wdata_i),
    .err_cnt_o   (err_cnt),
    .pend_cnt_o  (pend_cnt)
  );

  always #5ns clk_i = ~clk_i;

  always @(posedge clk_i) begin
    cycle_cnt++;
    if (cycle_cnt > CYCLE_LIMIT) begin
      $display("%0t: timeout, %0d result items outstanding", $time, pend_cnt);
      $display("Regression FAIL");
      $finish;
    end
  end

  // receiver back-pressure: free running, coin toss, or long stalls
  always @(negedge clk_i) begin
    if (rx_mode_left == 0) begin
      rx_mode      = rx_mode_e'($urandom_range(2, 0));
      rx_mode_left = $urandom_range(300, 40);
    end
    rx_mode_left--;
    case (rx_mode)
      RX_FREE: out_ch.ready <= 1'b1;
      RX_COIN: out_ch.ready <= 1'($urandom_range(1, 0));
      default: begin
        if (rx_hold_left == 0) begin
          rx_lvl       = !rx_lvl;
          rx_hold_left = rx_lvl ? $urandom_range(8, 1) : $urandom_range(12, 1);
        end
        rx_hold_left--;
        out_ch.ready <= rx_lvl;
      end
    endcase
  end

  task automatic push_item(input logic cmd, input logic [CODE_W-1:0] code);
    in_ch.valid       <= 1'b1;
    in_ch.cmd         <= cmd;
    in_ch.button_code <= code;
    @(posedge clk_i);
    while (!in_ch.ready) @(posedge clk_i);
    @(negedge clk_i);
    burst_left--;
    if (burst_left == 0) begin
      burst_left = $urandom_range(40, 1);
      if ($urandom_range(3, 0) != 0) begin
        in_ch.valid <= 1'b0;
        repeat ($urandom_range(6, 1)) @(negedge clk_i);
      end
    end
  endtask

  task automatic drain();
    in_ch.valid <= 1'b0;
    wait (pend_cnt == 0);
    repeat (4) @(negedge clk_i);
  endtask

  task automatic write_cfg(input logic [REPEAT_W-1:0] rep, input logic [ADDR_W-1:0] addr);
    cfg_we_i    <= 1'b1;
    cfg_idx_i   <= CFG_REPEAT;
    cfg_wdata_i <= CFG_DATA_W'(rep);
    @(negedge clk_i);
    cfg_idx_i   <= CFG_ADDR;
    cfg_wdata_i <= CFG_DATA_W'(addr);
    @(negedge clk_i);
    cfg_we_i    <= 1'b0;
  endtask

  // mostly ticks so that whole frames and repetitions play out
  task automatic run_phase(input logic [REPEAT_W-1:0] rep, input logic [ADDR_W-1:0] addr);
    int unsigned n_items;
    n_items = 40 + 95 * ((rep == '0) ? 1 : rep);
    drain();
    write_cfg(rep, addr);
    repeat (n_items) begin
      if ($urandom_range(24, 0) == 0) push_item(CMD_SEND, CODE_W'($urandom));
      else push_item(CMD_TICK, CODE_W'($urandom));
    end
  endtask

  initial begin
    in_ch.valid       = 1'b0;
    in_ch.cmd         = CMD_TICK;
    in_ch.button_code = '0;
    repeat (12) @(negedge clk_i);
    rst_ni <= 1'b1;
    @(negedge clk_i);

    // idle tick, accepted send, refused sends at reset settings
    push_item(CMD_TICK, '0);
    push_item(CMD_SEND, 7'h00);
    push_item(CMD_SEND, 7'h7F);
    repeat (5) push_item(CMD_TICK, 7'h7F);
    push_item(CMD_SEND, 7'h2A);
    repeat (4) push_item(CMD_TICK, '0);

    run_phase(3'd1, 7'h00);
    run_phase(3'd7, 7'h7F);
    run_phase(3'd0, ADDR_W'($urandom));
    run_phase(3'd2, 7'h55);
    run_phase(3'd3, 7'h2A);

    drain();
    repeat (4) @(negedge clk_i);
    if (err_cnt == 0) begin
      $display("Regression PASS");
    end else begin
      $display("Regression FAIL");
    end
    $finish;
  end

endmodule

FILE: remote_pulse_length_serializer.f
src/rpls_pkg.sv
src/rpls_in_if.sv
src/rpls_out_if.sv
src/rpls_front.sv
src/rpls_back.sv
src/remote_pulse_length_serializer.sv
dv/rpls_checker.sv
dv/remote_pulse_length_serializer_tb.sv
